### rtl/assert_macros.svh
// Shared assertion macros for the hash engine checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define B2S_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define B2S_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### rtl/b2s_pkg.sv
// ----------------------------------------------------------------------------
// b2s_pkg
// Constants, tables and helpers shared by the BLAKE2s engine files.
// ----------------------------------------------------------------------------
package b2s_pkg;

	localparam int WORD_W   = 32;
	localparam int MSG_DEPTH = 16;
	localparam int CV_DEPTH  = 8;
	localparam logic [5:0] LEN_RESET = 6'd32;
	localparam logic [31:0] PARAM_WORD = 32'h0101_0000;
	localparam logic [7:0] LAST_STEP = 8'd160;

	localparam logic [31:0] IV [8] = '{
		32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
		32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
	};

	// Message schedule, one row per round, entry i in nibble i; rows 10..15 unused
	localparam logic [63:0] SIGMA [16] = '{
		64'hFEDCBA9876543210, 64'h357B20C16DF984AE, 64'h491763EADF250C8B,
		64'h8F04A562EBCD1397, 64'hD386CB1EFA427509, 64'h91EF57D438B0A6C2,
		64'hB8293670A4DEF15C, 64'hA2684F05931CE7BD, 64'h5A417D2C803B9EF6,
		64'h0DC3E9BF5167482A, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0
	};

	function automatic logic [3:0] perm_idx(logic [3:0] rnd, logic [3:0] pos);
		logic [63:0] row;
		row = SIGMA[rnd];
		return row[{pos, 2'b00} +: 4];
	endfunction

	// Digest length clamped to 1..32
	function automatic logic [5:0] eff_len(logic [5:0] len);
		logic [5:0] r;
		if (len == 6'd0) r = 6'd1;
		else if (len > 6'd32) r = 6'd32;
		else r = len;
		return r;
	endfunction

	// Initial chain value word, parameter block mixed into word 0
	function automatic logic [31:0] iv_word(logic [2:0] idx, logic [5:0] len);
		logic [31:0] w;
		w = IV[idx];
		if (idx == 3'd0) w = w ^ PARAM_WORD ^ {26'd0, eff_len(len)};
		return w;
	endfunction

	// Low-byte mask for 0..4 valid bytes
	function automatic logic [31:0] byte_mask(logic [2:0] n);
		logic [31:0] m;
		unique case (n)
			3'd0: m = 32'h0000_0000;
			3'd1: m = 32'h0000_00FF;
			3'd2: m = 32'h0000_FFFF;
			3'd3: m = 32'h00FF_FFFF;
			default: m = 32'hFFFF_FFFF;
		endcase
		return m;
	endfunction

	typedef struct packed {
		logic [3:0] a;
		logic [3:0] b;
		logic [3:0] c;
		logic [3:0] d;
	} gidx_t;

	// Working-vector indices of mix j (columns then diagonals)
	function automatic gidx_t g_index(logic [2:0] j);
		gidx_t g;
		logic [1:0] jj;
		jj = j[1:0];
		g.a = {2'b00, jj};
		if (!j[2]) begin
			g.b = {2'b01, jj};
			g.c = {2'b10, jj};
			g.d = {2'b11, jj};
		end else begin
			g.b = {2'b01, jj + 2'd1};
			g.c = {2'b10, jj + 2'd2};
			g.d = {2'b11, jj + 2'd3};
		end
		return g;
	endfunction

endpackage

### rtl/b2s_if.sv
// ----------------------------------------------------------------------------
// b2s_if
// Stream channels of the hash engine: message in, digest out, config write.
// ----------------------------------------------------------------------------
interface b2s_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] data_word;
	logic [2:0]  byte_count;
	logic        last_item;
	modport source(output valid, data_word, byte_count, last_item, input ready);
	modport sink(input valid, data_word, byte_count, last_item, output ready);
endinterface

interface b2s_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic [2:0]  valid_bytes;
	logic        error;
	logic        last_word;
	modport source(output valid, digest_word, word_index, valid_bytes, error,
		last_word, input ready);
	modport sink(input valid, digest_word, word_index, valid_bytes, error,
		last_word, output ready);
endinterface

interface b2s_cfg_if;
	logic       valid;
	logic       ready;
	logic [5:0] dig_len;
	modport source(output valid, dig_len, input ready);
	modport sink(input valid, dig_len, output ready);
endinterface

### rtl/blake2s_hash_engine.sv
// A word item is registered in idle and written to the message RAM in append;
// a full block compresses via chain loads, 160 half-G steps, chain write-backs.
// Final item: any zero padding, one compression, then per digest word a RAM
// read, an output load and the handshake. Throughput set by the single mixer.
// Reset: digest length 32, chain value reads as IV, buffer and counter empty.
// ----------------------------------------------------------------------------
// blake2s_hash_engine
// Unkeyed BLAKE2s engine; message and chain value kept in on-chip RAMs.
// ----------------------------------------------------------------------------
module blake2s_hash_engine (
	input  logic             clk,
	input  logic             arst_n,
	b2s_in_if.sink           in_ch,
	b2s_out_if.source        out_ch,
	b2s_cfg_if.sink          cfg_ch
);

	typedef enum logic [3:0] {
		S_IDLE, S_APPEND, S_ZERO, S_LOAD, S_ROUND, S_FIN, S_ERD, S_ELD, S_EWAIT
	} state_t;

	state_t      state_q;
	logic [5:0]  len_q;
	logic [6:0]  fill_q;
	logic [63:0] cnt_q;
	logic [7:0]  cvvalid_q;
	logic [31:0] data_q;
	logic [2:0]  n_q;
	logic        last_q;
	logic        final_q;
	logic [7:0]  step_q;
	logic [3:0]  zidx_q;
	logic [3:0]  k_q;
	logic [31:0] v_q [16];
	logic        cv_sel_q;
	logic [2:0]  cv_addr_q;
	logic        out_valid_q;
	logic [31:0] out_word_q;
	logic [2:0]  out_idx_q;
	logic [2:0]  out_vb_q;
	logic        out_err_q;
	logic        out_last_q;

	// message RAM ports
	logic        msg_we;
	logic [3:0]  msg_waddr, msg_raddr;
	logic [31:0] msg_wdata, msg_rdata;
	// chain value RAM ports
	logic        cv_we;
	logic [2:0]  cv_waddr;
	logic [31:0] cv_wdata, cv_rdata, cv_rd;

	logic [2:0]  n_in;
	logic [6:0]  fill_new;
	logic [6:0]  zidx_new;
	logic [2:0]  km1;
	logic [7:0]  h;
	b2s_pkg::gidx_t gi;
	logic [31:0] ga, gb, gc, gd;
	logic [5:0]  elen, rem;
	logic [3:0]  words;
	logic [2:0]  vb;

	b2s_ram #(.WIDTH(b2s_pkg::WORD_W), .DEPTH(b2s_pkg::MSG_DEPTH)) u_msg_ram (
		.clk(clk), .we(msg_we), .waddr(msg_waddr), .wdata(msg_wdata),
		.raddr(msg_raddr), .rdata(msg_rdata)
	);

	b2s_ram #(.WIDTH(b2s_pkg::WORD_W), .DEPTH(b2s_pkg::CV_DEPTH)) u_cv_ram (
		.clk(clk), .we(cv_we), .waddr(cv_waddr), .wdata(cv_wdata),
		.raddr(k_q[2:0]), .rdata(cv_rdata)
	);

	// unwritten chain entries read as the initial value
	assign cv_rd = cv_sel_q ? b2s_pkg::iv_word(cv_addr_q, len_q) : cv_rdata;

	// half-G step for the previous step count
	assign h  = step_q - 8'd1;
	assign gi = b2s_pkg::g_index(h[3:1]);

	b2s_gmix u_gmix (
		.a(v_q[gi.a]), .b(v_q[gi.b]), .c(v_q[gi.c]), .d(v_q[gi.d]),
		.m(msg_rdata), .second(h[0]),
		.a_o(ga), .b_o(gb), .c_o(gc), .d_o(gd)
	);

	// item decode and fill arithmetic
	assign n_in     = (in_ch.byte_count > 3'd4) ? 3'd4 : in_ch.byte_count;
	assign fill_new = fill_q + {4'd0, n_q};
	assign zidx_new = (fill_new + 7'd3) >> 2;
	assign km1      = k_q[2:0] - 3'd1;

	// digest word geometry
	assign elen  = b2s_pkg::eff_len(len_q);
	assign words = 4'((elen + 6'd3) >> 2);
	assign rem   = elen - {1'b0, k_q[2:0], 2'b00};
	assign vb    = (rem > 6'd4) ? 3'd4 : rem[2:0];

	// RAM write and read address control
	always_comb begin
		msg_we    = 1'b0;
		msg_waddr = zidx_q;
		msg_wdata = '0;
		if (state_q == S_APPEND && n_q != 3'd0) begin
			msg_we    = 1'b1;
			msg_waddr = fill_q[5:2];
			msg_wdata = data_q & b2s_pkg::byte_mask(n_q);
		end else if (state_q == S_ZERO) begin
			msg_we = 1'b1;
		end
		msg_raddr = b2s_pkg::perm_idx(step_q[7:4], step_q[3:0]);
		cv_we    = (state_q == S_FIN) && (k_q != 4'd0);
		cv_waddr = km1;
		cv_wdata = cv_rd ^ v_q[{1'b0, km1}] ^ v_q[{1'b1, km1}];
	end

	assign in_ch.ready        = (state_q == S_IDLE);
	assign cfg_ch.ready       = 1'b1;
	assign out_ch.valid       = out_valid_q;
	assign out_ch.digest_word = out_word_q;
	assign out_ch.word_index  = out_idx_q;
	assign out_ch.valid_bytes = out_vb_q;
	assign out_ch.error       = out_err_q;
	assign out_ch.last_word   = out_last_q;

	// payload registers
	always_ff @(posedge clk) begin
		cv_addr_q <= k_q[2:0];
		if (state_q == S_IDLE && in_ch.valid) begin
			data_q <= in_ch.data_word;
			n_q    <= n_in;
			last_q <= in_ch.last_item;
		end
		if (state_q == S_LOAD) begin
			if (k_q == 4'd0) begin
				for (int i = 0; i < 8; i++) v_q[8 + i] <= b2s_pkg::IV[i];
				v_q[12] <= b2s_pkg::IV[4] ^ cnt_q[31:0];
				v_q[13] <= b2s_pkg::IV[5] ^ cnt_q[63:32];
				v_q[14] <= final_q ? ~b2s_pkg::IV[6] : b2s_pkg::IV[6];
			end else begin
				v_q[{1'b0, km1}] <= cv_rd;
			end
		end
		if (state_q == S_ROUND && step_q != 8'd0) begin
			v_q[gi.a] <= ga;
			v_q[gi.b] <= gb;
			v_q[gi.c] <= gc;
			v_q[gi.d] <= gd;
		end
	end

	// control state machine and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			len_q       <= b2s_pkg::LEN_RESET;
			fill_q      <= '0;
			cnt_q       <= '0;
			cvvalid_q   <= '0;
			final_q     <= 1'b0;
			step_q      <= '0;
			zidx_q      <= '0;
			k_q         <= '0;
			cv_sel_q    <= 1'b1;
			out_valid_q <= 1'b0;
			out_word_q  <= '0;
			out_idx_q   <= '0;
			out_vb_q    <= '0;
			out_err_q   <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			cv_sel_q <= !cvvalid_q[k_q[2:0]];
			unique case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						if (!in_ch.last_item && n_in != 3'd4) begin
							out_valid_q <= 1'b1;
							out_word_q  <= '0;
							out_idx_q   <= '0;
							out_vb_q    <= '0;
							out_err_q   <= 1'b1;
							out_last_q  <= 1'b1;
							state_q     <= S_EWAIT;
						end else if (n_in != 3'd0 && fill_q[6]) begin
							// full block pending and more bytes follow
							cnt_q   <= cnt_q + 64'd64;
							fill_q  <= '0;
							final_q <= 1'b0;
							k_q     <= '0;
							state_q <= S_LOAD;
						end else begin
							state_q <= S_APPEND;
						end
					end
				end
				S_APPEND: begin
					fill_q <= fill_new;
					if (last_q) begin
						cnt_q <= cnt_q + {57'd0, fill_new};
						if (zidx_new[4]) begin
							final_q <= 1'b1;
							k_q     <= '0;
							state_q <= S_LOAD;
						end else begin
							zidx_q  <= zidx_new[3:0];
							state_q <= S_ZERO;
						end
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_ZERO: begin
					if (zidx_q == 4'd15) begin
						final_q <= 1'b1;
						k_q     <= '0;
						state_q <= S_LOAD;
					end else begin
						zidx_q <= zidx_q + 4'd1;
					end
				end
				S_LOAD: begin
					if (k_q == 4'd8) begin
						step_q  <= '0;
						state_q <= S_ROUND;
					end else begin
						k_q <= k_q + 4'd1;
					end
				end
				S_ROUND: begin
					if (step_q == b2s_pkg::LAST_STEP) begin
						k_q     <= '0;
						state_q <= S_FIN;
					end else begin
						step_q <= step_q + 8'd1;
					end
				end
				S_FIN: begin
					if (k_q != 4'd0) cvvalid_q[km1] <= 1'b1;
					if (k_q == 4'd8) begin
						k_q     <= '0;
						state_q <= final_q ? S_ERD : S_APPEND;
					end else begin
						k_q <= k_q + 4'd1;
					end
				end
				S_ERD: begin
					state_q <= S_ELD;
				end
				S_ELD: begin
					out_valid_q <= 1'b1;
					out_word_q  <= cv_rd & b2s_pkg::byte_mask(vb);
					out_idx_q   <= k_q[2:0];
					out_vb_q    <= vb;
					out_err_q   <= 1'b0;
					out_last_q  <= (k_q + 4'd1 == words);
					state_q     <= S_EWAIT;
				end
				S_EWAIT: begin
					if (out_ch.ready) begin
						out_valid_q <= 1'b0;
						if (out_last_q) begin
							if (!out_err_q) begin
								cvvalid_q <= '0;
								fill_q    <= '0;
								cnt_q     <= '0;
							end
							k_q     <= '0;
							state_q <= S_IDLE;
						end else begin
							k_q     <= k_q + 4'd1;
							state_q <= S_ERD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
			// register write restarts the message
			if (cfg_ch.valid) begin
				len_q     <= cfg_ch.dig_len;
				cvvalid_q <= '0;
				fill_q    <= '0;
				cnt_q     <= '0;
			end
		end
	end

endmodule

### rtl/b2s_ram.sv
// ----------------------------------------------------------------------------
// b2s_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module b2s_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

### rtl/b2s_gmix.sv
// ----------------------------------------------------------------------------
// b2s_gmix
// One half of the BLAKE2s G function: add, xor, rotate on four words.
// ----------------------------------------------------------------------------
module b2s_gmix (
	input  logic [31:0] a,
	input  logic [31:0] b,
	input  logic [31:0] c,
	input  logic [31:0] d,
	input  logic [31:0] m,
	input  logic        second,
	output logic [31:0] a_o,
	output logic [31:0] b_o,
	output logic [31:0] c_o,
	output logic [31:0] d_o
);

	logic [31:0] dx, bx;

	// first half rotates by 16/12, second by 8/7
	always_comb begin
		a_o = a + b + m;
		dx  = d ^ a_o;
		d_o = second ? {dx[7:0], dx[31:8]} : {dx[15:0], dx[31:16]};
		c_o = c + d_o;
		bx  = b ^ c_o;
		b_o = second ? {bx[6:0], bx[31:7]} : {bx[11:0], bx[31:12]};
	end

endmodule

### rtl/b2s_checker.sv
// ----------------------------------------------------------------------------
// b2s_checker
// Port-level checks on the hash engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module b2s_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  word_index,
	input logic [2:0]  valid_bytes,
	input logic        error,
	input logic        last_word
);

	// a pending result holds until taken
	`B2S_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)

	// no new item is taken while a result waits
	`B2S_ASSERT_IMP(a_no_in_while_out, clk, arst_n, out_valid, !in_ready)

	// error result is a single empty word
	`B2S_ASSERT_IMP(a_err_shape, clk, arst_n, out_valid && error,
		valid_bytes == 3'd0 && last_word && word_index == 3'd0)

	// digest words carry one to four bytes
	`B2S_ASSERT_IMP(a_dig_bytes, clk, arst_n, out_valid && !error,
		valid_bytes != 3'd0 && valid_bytes <= 3'd4)

	// a non-final digest word is full
	`B2S_ASSERT_IMP(a_full_mid, clk, arst_n, out_valid && !error && !last_word,
		valid_bytes == 3'd4)

endmodule

bind blake2s_hash_engine b2s_checker u_b2s_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_ready(in_ch.ready),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.word_index(out_ch.word_index),
	.valid_bytes(out_ch.valid_bytes),
	.error(out_ch.error),
	.last_word(out_ch.last_word)
);
